// ===== hdl/psms_pkg.sv =====
`timescale 1ns / 1ps

package psms_pkg;

  localparam int MAX_SIZE_DEF = 16;

  localparam int REQ_TYPE_W = 2;
  localparam int COORD_W    = 4;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int SIZE_W     = 5;
  localparam int PIDX_W     = 8;   // packed index of a 4-bit row/col pair, max 135
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // request codes
  localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // register index, taken from paddr[2]
  localparam logic CFG_MATRIX_SIZE = 1'b0;

  localparam logic [SIZE_W-1:0] MATRIX_SIZE_RST = 5'd16;

  typedef struct packed {
    logic              in_range;
    logic [PIDX_W-1:0] idx;
  } pidx_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic                      symmetric;
  } rsp_t;

  // memory word: loaded mark over the stored value
  typedef struct packed {
    logic               loaded;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

// ===== hdl/psms_if.sv =====
`timescale 1ns / 1ps

interface psms_req_if import psms_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [REQ_TYPE_W-1:0]     req_type;
  logic [COORD_W-1:0]        row;
  logic [COORD_W-1:0]        col;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, req_type, row, col, value, input ready);
  modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface psms_rsp_if import psms_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic [STATUS_W-1:0]       status;
  logic                      symmetric;

  modport source (output valid, read_value, status, symmetric, input ready);
  modport sink   (input valid, read_value, status, symmetric, output ready);
endinterface

// ===== hdl/psms_ram.sv =====
`timescale 1ns / 1ps

module psms_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 136,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/psms_cfg.sv =====
`timescale 1ns / 1ps

module psms_cfg import psms_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [SIZE_W-1:0]     eff_size
);

  localparam logic [7:0] MAX8 = 8'(MAX_SIZE);

  logic [SIZE_W-1:0] matrix_size;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == CFG_MATRIX_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= MATRIX_SIZE_RST;
    end else if (wr_en) begin
      matrix_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_MATRIX_SIZE) begin
      prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, matrix_size};
    end
  end

  // size saturates at the built MAX_SIZE
  assign eff_size = ({3'b000, matrix_size} > MAX8) ? SIZE_W'(MAX_SIZE) : matrix_size;

endmodule

// ===== hdl/psms_index.sv =====
`timescale 1ns / 1ps

module psms_index import psms_pkg::*; (
  input  logic [SIZE_W-1:0]  eff_size,
  input  logic [COORD_W-1:0] row,
  input  logic [COORD_W-1:0] col,
  output pidx_t              pidx
);

  logic [COORD_W-1:0] hi;
  logic [COORD_W-1:0] lo;
  logic [PIDX_W-1:0]  hi_w;
  logic [PIDX_W-1:0]  tri_prod;

  assign hi   = (row >= col) ? row : col;
  assign lo   = (row >= col) ? col : row;
  assign hi_w = {{(PIDX_W-COORD_W){1'b0}}, hi};

  // hi*(hi+1) stays below 256 for a 4-bit hi
  assign tri_prod = hi_w * (hi_w + PIDX_W'(1));

  assign pidx.in_range = ({1'b0, row} < eff_size) && ({1'b0, col} < eff_size);
  assign pidx.idx      = (tri_prod >> 1) + {{(PIDX_W-COORD_W){1'b0}}, lo};

endmodule

// ===== hdl/packed_symmetric_matrix_store.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// req       in   valid/ready        req_type, row, col, value
// rsp       out  valid/ready        read_value, status, symmetric
// apb       in   psel/penable       paddr, pwdata, prdata (matrix_size at 0)
//
// each request is indexed and read from memory, then checked and written back
// sustained rate is one request per cycle while no clearing pass runs and rsp is
// not stalled; the single memory port pair sets it. a clear request and reset each
// start a clearing pass over all DEPTH words (136 at the default size), taking no
// request; rst is synchronous; req.ready drops once queue and stage 1 hold two results
module packed_symmetric_matrix_store import psms_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  psms_req_if.sink              req,
  psms_rsp_if.source            rsp
);

  localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = VALUE_W + 1;

  // configuration
  logic [SIZE_W-1:0] eff_size;

  psms_cfg #(.MAX_SIZE(MAX_SIZE)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .eff_size (eff_size)
  );

  // index of the incoming request
  pidx_t pidx;

  psms_index u_index (
    .eff_size (eff_size),
    .row      (req.row),
    .col      (req.col),
    .pidx     (pidx)
  );

  // stage 1 registers: request waiting for its memory word
  logic                  s1_valid;
  logic [REQ_TYPE_W-1:0] s1_req;
  logic                  s1_in_range;
  logic [AW-1:0]         s1_idx;
  logic [VALUE_W-1:0]    s1_value;

  // clearing pass
  logic          sweeping;
  logic [AW-1:0] sweep_cnt;

  // sticky symmetric flag
  logic sym_flag;
  logic sym_flag_next;

  // memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [EW-1:0] ram_rdata;

  // last write, for a read issued at the same edge
  logic          wr_last_valid;
  logic [AW-1:0] wr_last_addr;
  entry_t        wr_last_data;
  entry_t        cur_entry;

  // result queue, two deep
  rsp_t       rsp_buf [2];
  logic       rsp_wptr;
  logic       rsp_rptr;
  logic [1:0] rsp_cnt;
  logic       push;
  logic       pop;
  rsp_t       s1_rsp;

  logic accept;
  logic s1_clear;

  assign s1_clear = s1_valid && (s1_req == REQ_CLEAR);
  assign pop      = rsp.valid && rsp.ready;
  assign push     = s1_valid;

  // room for the new request once the one in stage 1 lands
  assign req.ready = !sweeping && !s1_clear &&
                     (({1'b0, rsp_cnt} + {2'b00, s1_valid}) < (3'd2 + {2'b00, pop}));
  assign accept    = req.valid && req.ready;

  psms_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (AW'(pidx.idx)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req      <= req.req_type;
      s1_in_range <= pidx.in_range;
      s1_idx      <= AW'(pidx.idx);
      s1_value    <= req.value;
    end
  end

  // forward the word written at the edge that issued this read
  assign cur_entry = (wr_last_valid && (wr_last_addr == s1_idx)) ? wr_last_data
                                                                 : entry_t'(ram_rdata);

  // clearing-pass write, else check, write back and build the result
  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = s1_idx;
    ram_wdata        = '0;
    sym_flag_next    = sym_flag;
    s1_rsp           = '0;
    if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt;
    end else if (s1_valid) begin
      case (s1_req)
        REQ_CLEAR: begin
          sym_flag_next = 1'b1;
        end
        REQ_LOAD: begin
          if (!s1_in_range) begin
            s1_rsp.status = ST_RANGE;
          end else if (!cur_entry.loaded) begin
            ram_we           = 1'b1;
            ram_wdata.loaded = 1'b1;
            ram_wdata.value  = s1_value;
          end else if (cur_entry.value != s1_value) begin
            sym_flag_next = 1'b0;
          end
        end
        REQ_READ: begin
          if (!s1_in_range) begin
            s1_rsp.status = ST_RANGE;
          end else if (cur_entry.loaded) begin
            s1_rsp.read_value = cur_entry.value;
          end else begin
            s1_rsp.status = ST_EMPTY;
          end
        end
        default: ;
      endcase
    end
    s1_rsp.symmetric = sym_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_flag      <= 1'b1;
      wr_last_valid <= 1'b0;
    end else begin
      sym_flag      <= sym_flag_next;
      wr_last_valid <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    wr_last_addr <= ram_waddr;
    wr_last_data <= ram_wdata;
  end

  // clearing pass after reset and after every clear request
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping  <= 1'b1;
      sweep_cnt <= '0;
    end else if (sweeping) begin
      if (sweep_cnt == AW'(DEPTH - 1)) begin
        sweeping <= 1'b0;
      end
      sweep_cnt <= sweep_cnt + AW'(1);
    end else if (s1_clear) begin
      sweeping  <= 1'b1;
      sweep_cnt <= '0;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_wptr <= 1'b0;
      rsp_rptr <= 1'b0;
      rsp_cnt  <= '0;
    end else begin
      if (push) begin
        rsp_wptr <= !rsp_wptr;
      end
      if (pop) begin
        rsp_rptr <= !rsp_rptr;
      end
      rsp_cnt <= rsp_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp_buf[rsp_wptr] <= s1_rsp;
    end
  end

  assign rsp.valid      = (rsp_cnt != 2'd0);
  assign rsp.read_value = rsp_buf[rsp_rptr].read_value;
  assign rsp.status     = rsp_buf[rsp_rptr].status;
  assign rsp.symmetric  = rsp_buf[rsp_rptr].symmetric;

  // no request taken while the store is being cleared
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !accept)
    else $error("request taken during clearing pass");

  // a clear request always starts a clearing pass and sets the flag
  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    s1_clear |=> (sweeping && sym_flag))
    else $error("clear did not start clearing pass");

  // result queue never overflows
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (rsp_cnt == 2'd2) |-> !push || pop)
    else $error("result queue overflow");

  // the flag only falls on a mismatching load
  a_flag_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(sym_flag) |-> $past(s1_valid && (s1_req == REQ_LOAD)))
    else $error("symmetric flag cleared without a load");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb import psms_pkg::*; ();

  // packed lower triangle of the largest matrix
  localparam int DEPTH = MAX_SIZE_DEF * (MAX_SIZE_DEF + 1) / 2;

  // request code that the block must answer but otherwise ignore
  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

  // byte address of matrix_size, register index sits in paddr[2]
  localparam logic [APB_ADDR_W-1:0] MATRIX_SIZE_ADDR = {CFG_MATRIX_SIZE, 2'b00};

  // generous ceiling on the run length
  localparam int CYCLE_LIMIT   = 400000;
  // settle time after the last drain, covers a stray late response
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 72;
  localparam int PRINT_LIMIT   = 100;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [REQ_TYPE_W-1:0]     req_type;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [VALUE_W-1:0] value;
  } matrix_req_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  psms_req_if req_bus ();
  psms_rsp_if rsp_bus ();

  packed_symmetric_matrix_store #(
    .MAX_SIZE (MAX_SIZE_DEF)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_bus),
    .rsp     (rsp_bus)
  );

  // requests waiting to be driven, answers waiting to come back
  matrix_req_t pending_requests[$];
  rsp_t        answer_queue[$];

  // our own copy of the matrix store, flag and size register
  logic [VALUE_W-1:0] mirror_value [DEPTH];
  bit                 mirror_loaded [DEPTH];
  bit                 mirror_symmetric;
  logic [SIZE_W-1:0]  mirror_size;

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int          error_count;
  int          cycle_count;
  logic        req_fire;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // size in use: anything above the array size saturates
  function automatic int unsigned active_size(logic [SIZE_W-1:0] sz);
    return (sz > MAX_SIZE_DEF) ? MAX_SIZE_DEF : 32'(sz);
  endfunction

  // applies one request to the mirror and returns the answer it must produce
  function automatic rsp_t matrix_answer(matrix_req_t rq);
    rsp_t        ans;
    int unsigned lim;
    int unsigned hi;
    int unsigned lo;
    int unsigned idx;
    ans.read_value = '0;
    ans.status     = ST_OK;
    lim = active_size(mirror_size);
    if (rq.req_type == REQ_CLEAR) begin
      // clear drops the loaded marks only, stale values stay behind
      mirror_loaded    = '{default: 1'b0};
      mirror_symmetric = 1'b1;
    end else if (rq.req_type == REQ_LOAD || rq.req_type == REQ_READ) begin
      if (rq.row >= lim || rq.col >= lim) begin
        ans.status = ST_RANGE;
      end else begin
        // fold onto the lower triangle
        hi  = (rq.row >= rq.col) ? 32'(rq.row) : 32'(rq.col);
        lo  = (rq.row >= rq.col) ? 32'(rq.col) : 32'(rq.row);
        idx = hi * (hi + 1) / 2 + lo;
        if (rq.req_type == REQ_LOAD) begin
          if (!mirror_loaded[idx]) begin
            mirror_value[idx]  = rq.value;
            mirror_loaded[idx] = 1'b1;
          end else if (mirror_value[idx] != rq.value) begin
            // later loads only compare, a difference is sticky until clear
            mirror_symmetric = 1'b0;
          end
        end else if (mirror_loaded[idx]) begin
          ans.read_value = mirror_value[idx];
        end else begin
          ans.status = ST_EMPTY;
        end
      end
    end
    // unused code falls through: no change, status ok
    ans.symmetric = mirror_symmetric;
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_LIMIT)
      $display("tb: mismatch on %s: got %08h want %08h at cycle %0d",
               what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic push_req(input logic [REQ_TYPE_W-1:0] kind, input int unsigned r,
                          input int unsigned c, input logic [VALUE_W-1:0] v);
    matrix_req_t rq;
    rq.req_type = kind;
    rq.row      = r[COORD_W-1:0];
    rq.col      = c[COORD_W-1:0];
    rq.value    = v;
    pending_requests.push_back(rq);
  endtask

  // mostly random words, now and then one of the corner values
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(2) == 0 ? 32'h0000_0000 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed traffic: mirrored load pairs and reads inside the
  // active size; the rest is range errors, clears, unused codes and noise
  task automatic add_random_items(input int count, input int unsigned lim);
    int unsigned      roll;
    int unsigned      r;
    int unsigned      c;
    logic [VALUE_W-1:0] v;
    int               n;
    n = 0;
    while (n < count) begin
      roll = $urandom_range(99);
      r = (lim > 0) ? $urandom_range(lim - 1) : $urandom_range(15);
      c = (lim > 0) ? $urandom_range(lim - 1) : $urandom_range(15);
      v = pick_value();
      if (roll < 40) begin
        // element and its mirror, sometimes disagreeing in one bit
        push_req(REQ_LOAD, r, c, v);
        if ($urandom_range(9) == 0)
          v = v ^ (32'h1 << $urandom_range(31));
        push_req(REQ_LOAD, c, r, v);
        n += 2;
      end else if (roll < 70) begin
        push_req(REQ_READ, r, c, '0);
        n++;
      end else if (roll < 78) begin
        push_req(REQ_LOAD, r, c, v);
        n++;
      end else if (roll < 86) begin
        // one coordinate at or past the active size where that exists
        if (lim < MAX_SIZE_DEF) begin
          if ($urandom_range(1) == 0) r = $urandom_range(15, lim);
          else c = $urandom_range(15, lim);
        end
        push_req($urandom_range(1) == 0 ? REQ_LOAD : REQ_READ, r, c, v);
        n++;
      end else if (roll < 90) begin
        push_req(REQ_CLEAR, $urandom_range(15), $urandom_range(15), $urandom);
        n++;
      end else if (roll < 93) begin
        push_req(REQ_UNUSED, $urandom_range(15), $urandom_range(15), $urandom);
        n++;
      end else begin
        push_req(REQ_TYPE_W'($urandom_range(3)), $urandom_range(15), $urandom_range(15),
                 $urandom);
        n++;
      end
    end
  endtask

  // idle means nothing queued, nothing on the bus, nothing outstanding
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_requests.size() != 0 || req_bus.valid || answer_queue.size() != 0);
  endtask

  // write the size register, then read it back
  task automatic write_matrix_size(input logic [SIZE_W-1:0] sz);
    logic [APB_DATA_W-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MATRIX_SIZE_ADDR;
    pwdata  <= {{(APB_DATA_W-SIZE_W){1'b0}}, sz};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mirror_size = sz;
    // read access follows straight on
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[SIZE_W-1:0] != sz)
      report_mismatch("matrix_size readback", readback, 32'(sz));
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct    = 77;
        receiver_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 77;
      end
      default: begin
        sender_idle_pct    = 11;
        receiver_stall_pct = 11;
      end
    endcase
  endtask

  // request driver: hold an offered request until it is taken, then
  // either offer the next one or idle
  always @(negedge clk) begin
    matrix_req_t rq;
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_fire) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        rq = pending_requests.pop_front();
        req_bus.req_type <= rq.req_type;
        req_bus.row      <= rq.row;
        req_bus.col      <= rq.col;
        req_bus.value    <= rq.value;
        req_bus.valid    <= 1'b1;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // response side back-pressure
  always @(negedge clk) begin
    rsp_bus.ready <= !rst && ($urandom_range(99) >= receiver_stall_pct);
  end

  // monitor: check responses against the oldest answer, then predict
  // for a request taken at the same edge (its answer is always younger)
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    req_fire <= !rst && req_bus.valid && req_bus.ready;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.read_value = rsp_bus.read_value;
      got.status     = rsp_bus.status;
      got.symmetric  = rsp_bus.symmetric;
      if (answer_queue.size() == 0) begin
        report_mismatch("response with no request outstanding", got.read_value, '0);
      end else begin
        want = answer_queue.pop_front();
        if (got.read_value !== want.read_value)
          report_mismatch("read_value", got.read_value, want.read_value);
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.symmetric !== want.symmetric)
          report_mismatch("symmetric", 32'(got.symmetric), 32'(want.symmetric));
      end
    end
    if (!rst && req_bus.valid && req_bus.ready) begin
      answer_queue.push_back(matrix_answer('{req_bus.req_type, req_bus.row,
                                              req_bus.col, req_bus.value}));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    logic [SIZE_W-1:0] phase_sizes [10];
    idle_mode_t        phase_modes [10];
    logic [VALUE_W-1:0] v;

    // saturating sizes and the empty matrix are part of the sweep
    phase_sizes = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd9, 5'd16, 5'd4, 5'd2, 5'd16};
    phase_modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE,
                    IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER};

    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_LOAD;
    req_bus.row      = '0;
    req_bus.col      = '0;
    req_bus.value    = '0;
    rsp_bus.ready    = 1'b0;
    req_fire         = 1'b0;
    error_count      = 0;
    cycle_count      = 0;
    mirror_value     = '{default: '0};
    mirror_loaded    = '{default: 1'b0};
    mirror_symmetric = 1'b1;
    mirror_size      = MATRIX_SIZE_RST;
    set_idle_mode(IDLE_NONE);

    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: corner values, mirrored pair, diagonal repeat, empty read,
    // unused code, clear restoring the flag, far corner of the triangle
    write_matrix_size(5'd16);
    v = 32'h1234_8765;
    push_req(REQ_LOAD,   0,  0, 32'h7fff_ffff);
    push_req(REQ_READ,   0,  0, '0);
    push_req(REQ_LOAD,  15, 15, 32'h8000_0000);
    push_req(REQ_READ,  15, 15, '0);
    push_req(REQ_LOAD,   3,  5, v);
    push_req(REQ_LOAD,   5,  3, v);
    push_req(REQ_READ,   5,  3, '0);
    push_req(REQ_READ,   3,  5, '0);
    push_req(REQ_READ,   2,  7, '0);
    push_req(REQ_LOAD,   0,  0, 32'h0000_0000);
    push_req(REQ_READ,   0,  0, '0);
    push_req(REQ_UNUSED, 15, 15, 32'hffff_ffff);
    push_req(REQ_CLEAR,  15, 15, 32'hffff_ffff);
    push_req(REQ_READ,   0,  0, '0);
    push_req(REQ_LOAD,  15,  0, 32'hffff_ffff);
    push_req(REQ_READ,   0, 15, '0);
    push_req(REQ_LOAD,   0, 15, 32'h0000_0000);
    wait_drained();

    // out of range against a smaller matrix
    write_matrix_size(5'd4);
    push_req(REQ_LOAD,  4,  0, 32'h0001_0000);
    push_req(REQ_READ,  0,  4, '0);
    push_req(REQ_READ, 15, 15, '0);
    push_req(REQ_LOAD,  3,  3, 32'hfffe_8000);
    push_req(REQ_READ,  3,  3, '0);
    wait_drained();

    // random phases; each one stops halfway until every answer is back
    for (int p = 0; p < 10; p++) begin
      set_idle_mode(phase_modes[p]);
      write_matrix_size(phase_sizes[p]);
      add_random_items(PHASE_ITEMS / 2, active_size(phase_sizes[p]));
      wait_drained();
      add_random_items(PHASE_ITEMS - PHASE_ITEMS / 2, active_size(phase_sizes[p]));
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;
    if (error_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
